### rtl/double_hash_open_addressing_table_core_macros.svh
// Assertion macros for the double-hashed table core.
`ifndef DOUBLE_HASH_OPEN_ADDRESSING_TABLE_CORE_MACROS_SVH
`define DOUBLE_HASH_OPEN_ADDRESSING_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DHOT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dhot assertion failed");
`define DHOT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("dhot forbidden condition");
`else
`define DHOT_ASSERT(lbl, clk, rstn, prop)
`define DHOT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### rtl/dhot_pkg.sv
`default_nettype none
package dhot_pkg;
  localparam int TableDepth = 1024;
  localparam int SlotW = $clog2(TableDepth);
  localparam int SizeW = 11;
  localparam int KeyW = 31;
  localparam int PayW = 32;
  localparam int MemW = 1 + KeyW + PayW;
  localparam logic [31:0] Golden = 32'h9E3779B9;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FOUND    = 2'd1,
    ST_MISSING  = 2'd2,
    ST_NO_SLOT  = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } fstate_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_EVAL
  } bstate_t;

  typedef struct packed {
    logic             op;
    logic [KeyW-1:0]  key;
    logic [PayW-1:0]  payload;
    logic [SlotW-1:0] home;
    logic [SlotW-1:0] step;
    logic [SizeW-1:0] size;
  } req_t;

  typedef struct packed {
    logic clearing;
  } bk_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;
endpackage
`default_nettype wire

### rtl/dhot_front.sv
`default_nettype none
module dhot_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_write_enable,
  input  wire logic [dhot_pkg::SizeW-1:0]   cfg_write_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_operation,
  input  wire logic [dhot_pkg::KeyW-1:0]    in_key,
  input  wire logic [dhot_pkg::PayW-1:0]    in_payload_in,
  input  wire dhot_pkg::bk_stat_t           bk_stat,
  input  wire dhot_pkg::q_stat_t            q_stat,
  output logic                              q_push,
  output dhot_pkg::req_t                    q_data
);
  dhot_pkg::fstate_t state_r, state_nxt;
  logic [dhot_pkg::SizeW-1:0] size_cfg_r;
  logic [dhot_pkg::SizeW-1:0] size_eff;
  logic [dhot_pkg::SizeW-1:0] size_r;
  logic [4:0] cnt_r;
  logic op_r;
  logic [dhot_pkg::KeyW-1:0] key_r, dividend_r;
  logic [dhot_pkg::PayW-1:0] pay_r;
  logic [dhot_pkg::SlotW-1:0] rem_r, rem_nxt, step_r;
  logic [dhot_pkg::SlotW:0] rem_sh;
  logic [31:0] frac_r, frac_nxt;
  logic [41:0] prod;
  logic accept;

  always_comb begin
    if (size_cfg_r == '0) begin
      size_eff = dhot_pkg::SizeW'(1);
    end else if (size_cfg_r > dhot_pkg::SizeW'(dhot_pkg::TableDepth)) begin
      size_eff = dhot_pkg::SizeW'(dhot_pkg::TableDepth);
    end else begin
      size_eff = size_cfg_r;
    end
  end

  assign rem_sh = {rem_r, dividend_r[dhot_pkg::KeyW-1]};
  assign rem_nxt = (rem_sh >= size_r) ? dhot_pkg::SlotW'(rem_sh - size_r)
                                      : dhot_pkg::SlotW'(rem_sh);
  assign frac_nxt = 32'({1'b0, key_r} * dhot_pkg::Golden);
  assign prod = 42'(size_r - dhot_pkg::SizeW'(1)) * 42'(frac_r);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dhot_pkg::F_IDLE: if (accept) state_nxt = dhot_pkg::F_DIV;
      dhot_pkg::F_DIV:  if (cnt_r == 5'd30) state_nxt = dhot_pkg::F_PUSH;
      dhot_pkg::F_PUSH: if (!q_stat.full) state_nxt = dhot_pkg::F_IDLE;
      default:          state_nxt = dhot_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    q_push = 1'b0;
    unique case (state_r)
      dhot_pkg::F_IDLE: in_ready = !bk_stat.clearing;
      dhot_pkg::F_PUSH: q_push = !q_stat.full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dhot_pkg::F_IDLE;
      size_cfg_r <= dhot_pkg::SizeW'(dhot_pkg::TableDepth);
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write_enable) size_cfg_r <= cfg_write_data;
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == dhot_pkg::F_DIV) begin
        cnt_r <= cnt_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_operation;
      key_r <= in_key;
      dividend_r <= in_key;
      pay_r <= in_payload_in;
      size_r <= size_eff;
      rem_r <= '0;
    end else if (state_r == dhot_pkg::F_DIV) begin
      dividend_r <= {dividend_r[dhot_pkg::KeyW-2:0], 1'b0};
      rem_r <= rem_nxt;
      if (cnt_r == 5'd0) frac_r <= frac_nxt;
      if (cnt_r == 5'd1) step_r <= prod[41:32] + dhot_pkg::SlotW'(1);
    end
  end

  assign q_data = '{op: op_r, key: key_r, payload: pay_r, home: rem_r,
                    step: step_r, size: size_r};
endmodule
`default_nettype wire

### rtl/dhot_fifo.sv
`default_nettype none
module dhot_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire dhot_pkg::req_t push_data,
  input  wire logic           pop,
  output dhot_pkg::req_t      pop_data,
  output dhot_pkg::q_stat_t   stat
);
  dhot_pkg::req_t ent_r [2];
  logic wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_data;
  end

  assign pop_data = ent_r[rd_ptr_r];
  assign stat = '{full: cnt_r == 2'd2, empty: cnt_r == 2'd0};
endmodule
`default_nettype wire

### rtl/dhot_back.sv
`default_nettype none
module dhot_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire dhot_pkg::q_stat_t           q_stat,
  input  wire dhot_pkg::req_t              q_data,
  output logic                             q_pop,
  output dhot_pkg::bk_stat_t               bk_stat,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic [dhot_pkg::PayW-1:0]        out_payload_out,
  output logic [dhot_pkg::SlotW-1:0]       out_slot_index
);
  dhot_pkg::bstate_t state_r, state_nxt;
  dhot_pkg::req_t cur_r;
  logic [dhot_pkg::SlotW-1:0] pos_r, clr_cnt_r, pos_nxt;
  logic [dhot_pkg::SizeW-1:0] i_r, cnt_r;
  logic [dhot_pkg::SlotW:0] pos_sum;
  logic [dhot_pkg::MemW-1:0] mem [dhot_pkg::TableDepth];
  logic [dhot_pkg::MemW-1:0] rd_r, wr_data;
  logic [dhot_pkg::SlotW-1:0] wr_addr;
  logic wr_en, rd_en;
  logic out_valid_r;
  dhot_pkg::status_t status_r, res_status;
  logic [dhot_pkg::PayW-1:0] pay_out_r, res_pay;
  logic [dhot_pkg::SlotW-1:0] slot_out_r;
  logic done, res_write, out_free, last_probe;
  logic slot_used, key_hit;

  assign slot_used = rd_r[dhot_pkg::MemW-1];
  assign key_hit = rd_r[dhot_pkg::MemW-2 -: dhot_pkg::KeyW] == cur_r.key;
  assign pos_sum = {1'b0, pos_r} + {1'b0, cur_r.step};
  assign pos_nxt = (pos_sum >= cur_r.size) ? dhot_pkg::SlotW'(pos_sum - cur_r.size)
                                           : dhot_pkg::SlotW'(pos_sum);
  assign last_probe = (i_r + dhot_pkg::SizeW'(1)) == cur_r.size;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    done = 1'b1;
    res_write = 1'b0;
    res_pay = '0;
    res_status = dhot_pkg::ST_MISSING;
    if (cur_r.op == dhot_pkg::OP_INSERT) begin
      res_status = dhot_pkg::ST_NO_SLOT;
      if (cnt_r >= cur_r.size) begin
        done = 1'b1;
      end else if (!slot_used) begin
        res_status = dhot_pkg::ST_INSERTED;
        res_write = 1'b1;
      end else begin
        done = last_probe;
      end
    end else begin
      if (!slot_used) begin
        done = 1'b1;
      end else if (key_hit) begin
        res_status = dhot_pkg::ST_FOUND;
        res_pay = rd_r[dhot_pkg::PayW-1:0];
      end else begin
        done = last_probe;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dhot_pkg::B_CLEAR: begin
        if (clr_cnt_r == dhot_pkg::SlotW'(dhot_pkg::TableDepth - 1)) begin
          state_nxt = dhot_pkg::B_IDLE;
        end
      end
      dhot_pkg::B_IDLE: if (!q_stat.empty) state_nxt = dhot_pkg::B_READ;
      dhot_pkg::B_READ: state_nxt = dhot_pkg::B_EVAL;
      dhot_pkg::B_EVAL: begin
        if (!done) begin
          state_nxt = dhot_pkg::B_READ;
        end else if (out_free) begin
          state_nxt = dhot_pkg::B_IDLE;
        end
      end
      default: state_nxt = dhot_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    rd_en = 1'b0;
    wr_en = 1'b0;
    wr_addr = pos_r;
    wr_data = {1'b1, cur_r.key, cur_r.payload};
    bk_stat = '{clearing: 1'b0};
    unique case (state_r)
      dhot_pkg::B_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = '0;
        bk_stat = '{clearing: 1'b1};
      end
      dhot_pkg::B_IDLE: q_pop = !q_stat.empty;
      dhot_pkg::B_READ: rd_en = 1'b1;
      dhot_pkg::B_EVAL: wr_en = done && out_free && res_write;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_r <= mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dhot_pkg::B_CLEAR;
      clr_cnt_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == dhot_pkg::B_CLEAR) clr_cnt_r <= clr_cnt_r + dhot_pkg::SlotW'(1);
      if (wr_en && state_r == dhot_pkg::B_EVAL) cnt_r <= cnt_r + dhot_pkg::SizeW'(1);
      if (state_r == dhot_pkg::B_EVAL && done && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
      pos_r <= q_data.home;
      i_r <= '0;
    end else if (state_r == dhot_pkg::B_EVAL && !done) begin
      pos_r <= pos_nxt;
      i_r <= i_r + dhot_pkg::SizeW'(1);
    end
    if (state_r == dhot_pkg::B_EVAL && done && out_free) begin
      status_r <= res_status;
      pay_out_r <= res_pay;
      slot_out_r <= (res_status == dhot_pkg::ST_INSERTED ||
                     res_status == dhot_pkg::ST_FOUND) ? pos_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_payload_out = pay_out_r;
  assign out_slot_index = slot_out_r;
endmodule
`default_nettype wire

### rtl/double_hash_open_addressing_table_core.sv
// Double-hashed open-addressing table of 1024 key and payload slots.
// Input words carry an operation (insert or search), a 31-bit key and a
// 32-bit payload; each accepted word yields exactly one result word with a
// status, the stored payload when found and the slot index.
// The size in use is written through cfg_write_enable and cfg_write_data;
// the user must write it only while the block is idle, as the block itself
// does not enforce this; zero is taken as one and values above 1024 as 1024.
// The front stage computes the home slot by restoring division, one quotient
// bit per cycle; a two-word queue then feeds the probe engine, which takes a
// word from the queue when idle and, for each probe, reads the table into a
// register in its read state and evaluates that word in its evaluate state.
// The front stage takes no new word until it has pushed the last one into the
// queue, so it can work on the next word while the probe engine works on one.
// After reset the probe engine clears every slot, one per cycle; in_ready
// stays low during that pass.
// The result register holds its word while out_ready is low; the probe engine
// then waits, the queue fills, and finally in_ready drops.
`default_nettype none
`include "double_hash_open_addressing_table_core_macros.svh"
module double_hash_open_addressing_table_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_write_enable,
  input  wire logic [dhot_pkg::SizeW-1:0]  cfg_write_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_operation,
  input  wire logic [dhot_pkg::KeyW-1:0]   in_key,
  input  wire logic [dhot_pkg::PayW-1:0]   in_payload_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic [dhot_pkg::PayW-1:0]        out_payload_out,
  output logic [dhot_pkg::SlotW-1:0]       out_slot_index
);
  dhot_pkg::req_t push_data, pop_data;
  dhot_pkg::q_stat_t q_stat;
  dhot_pkg::bk_stat_t bk_stat;
  logic q_push, q_pop;

  dhot_front u_front (
    .clk, .rst_n, .cfg_write_enable, .cfg_write_data,
    .in_valid, .in_ready, .in_operation, .in_key, .in_payload_in,
    .bk_stat, .q_stat, .q_push, .q_data(push_data)
  );

  dhot_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .push_data, .pop(q_pop), .pop_data,
    .stat(q_stat)
  );

  dhot_back u_back (
    .clk, .rst_n, .q_stat, .q_data(pop_data), .q_pop, .bk_stat,
    .out_valid, .out_ready, .out_status, .out_payload_out, .out_slot_index
  );

  `DHOT_NEVER(a_no_push_full, clk, rst_n, q_push && q_stat.full)
  `DHOT_NEVER(a_no_pop_empty, clk, rst_n, q_pop && q_stat.empty)
  `DHOT_NEVER(a_no_accept_clear, clk, rst_n, in_valid && in_ready && bk_stat.clearing)
  `DHOT_ASSERT(a_pop_then_wait, clk, rst_n, q_pop |=> !out_valid || !$rose(out_valid))
endmodule
`default_nettype wire
